// ===== hdl/flow_packet_stats_recorder_core_macros.svh =====
// assertion macros shared by the recorder checker
// no dependencies; included by files that hold concurrent assertions
`ifndef FLOW_PACKET_STATS_RECORDER_CORE_MACROS_SVH
`define FLOW_PACKET_STATS_RECORDER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FPSR_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("recorder check failed");

// next-cycle implication, disabled while reset is asserted
`define FPSR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("recorder check failed");

`endif

// ===== hdl/fpsr_pkg.sv =====
// types and constants for the flow packet statistics recorder
// no dependencies; used by every recorder module
package fpsr_pkg;

  // command codes; the unused fourth code behaves as a read
  localparam logic [1:0] CMD_PKT      = 2'd0;
  localparam logic [1:0] CMD_NEW      = 2'd1;
  localparam logic [1:0] CMD_READ     = 2'd2;
  localparam logic [1:0] CMD_READ_ALT = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SKIP_DUP  = 2'd0;
  localparam logic [1:0] REG_INC_ZERO  = 2'd1;

  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  // largest backward distance that still counts as not ahead
  localparam logic [31:0] WRAP_LIMIT = 32'd4252017623;

  typedef enum logic [2:0] {
    ST_RECORDED   = 3'd0,
    ST_DUP_DROP   = 3'd1,
    ST_ZERO_DROP  = 3'd2,
    ST_LIST_FULL  = 3'd3,
    ST_READ_OK    = 3'd4,
    ST_READ_EMPTY = 3'd5
  } status_t;

  // one stored packet record
  typedef struct packed {
    logic [15:0] size;
    logic [7:0]  flags;
    logic [31:0] seconds;
    logic [19:0] micros;
    logic        client;
  } entry_t;

  // tcp header snapshot kept per direction
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] len;
    logic [7:0]  flags;
  } tcp_snap_t;

  // update request to the per-direction state
  typedef struct packed {
    logic clear;
    logic write;
    logic dir;
  } dir_upd_t;

endpackage

// ===== hdl/flow_packet_stats_recorder_core.sv =====
// flow packet statistics recorder, top level
// depends on fpsr_pkg, fpsr_entry_mem and fpsr_dir_state
//
// Usage: a descriptor beat is taken on the edge where start is high and busy
// is low. busy is high for the one execute cycle that follows, so a new beat
// is taken only once busy falls again. In the execute cycle the registered
// descriptor is checked against the per-direction snapshot and the entry
// memory is written (record) or its read data, fetched at the accept edge, is
// used (read). The result is registered: out_valid pulses for one cycle,
// registered from busy, with status, slot, count and entry fields. There is no
// result back-pressure; the receiver must take every beat.
// The config channel (cfg_valid/cfg_ready, cfg_index, cfg_wdata) is always
// ready; the user must write it only while the block is idle, which the block
// itself does not enforce. Reset (rst_n low, synchronous) clears config, entry
// count and the per-direction snapshot; entry memory contents are left as they
// are, and their read data is never used for a slot before it is written.
module flow_packet_stats_recorder_core #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic              in_from_client,
  input  logic [7:0]        in_ip_protocol,
  input  logic [31:0]       in_seq_number,
  input  logic [31:0]       in_ack_number,
  input  logic [15:0]       in_payload_len,
  input  logic [15:0]       in_orig_payload_len,
  input  logic [7:0]        in_tcp_flags,
  input  logic [31:0]       in_time_seconds,
  input  logic [19:0]       in_time_micros,
  input  logic [4:0]        in_read_slot,
  // result channel
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [4:0]        out_slot,
  output logic [5:0]        out_entry_count,
  output logic [15:0]       out_entry_size,
  output logic [7:0]        out_entry_flags,
  output logic [31:0]       out_entry_seconds,
  output logic [19:0]       out_entry_micros,
  output logic signed [1:0] out_entry_direction,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic              cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  // control state
  logic             busy_r;
  logic             skip_dup_r;
  logic             inc_zero_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;

  // captured descriptor
  logic [1:0]  cmd_r;
  logic        client_r;
  logic [7:0]  proto_r;
  logic [31:0] seq_r;
  logic [31:0] ack_r;
  logic [15:0] plen_r;
  logic [15:0] olen_r;
  logic [7:0]  flags_r;
  logic [31:0] secs_r;
  logic [19:0] usec_r;
  logic [4:0]  rslot_r;

  // result registers
  fpsr_pkg::status_t status_r, status_nxt;
  logic [4:0]        slot_r, slot_nxt;
  logic [5:0]        ecount_r, ecount_nxt;
  logic [15:0]       esize_r, esize_nxt;
  logic [7:0]        eflags_r, eflags_nxt;
  logic [31:0]       esecs_r, esecs_nxt;
  logic [19:0]       eusec_r, eusec_nxt;
  logic signed [1:0] edir_r, edir_nxt;

  logic                accept;
  logic                cfg_wr;
  logic                is_read;
  logic                new_flow;
  logic [CNT_W-1:0]    count_eff;
  logic                has_room;
  logic                read_hit;
  logic                dup;
  logic                zero_drop;
  logic                dir_match;
  logic                mem_wr;
  fpsr_pkg::entry_t    wr_entry;
  fpsr_pkg::entry_t    rd_entry;
  fpsr_pkg::dir_upd_t  dir_upd;
  fpsr_pkg::tcp_snap_t cur_snap;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // busy for the single execute cycle after each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      count_r     <= count_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_dup_r <= 1'b0;
      inc_zero_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_index == fpsr_pkg::REG_SKIP_DUP) begin
        skip_dup_r <= cfg_wdata;
      end
      if (cfg_index == fpsr_pkg::REG_INC_ZERO) begin
        inc_zero_r <= cfg_wdata;
      end
    end
  end

  // capture the descriptor beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_command;
      client_r <= in_from_client;
      proto_r  <= in_ip_protocol;
      seq_r    <= in_seq_number;
      ack_r    <= in_ack_number;
      plen_r   <= in_payload_len;
      olen_r   <= in_orig_payload_len;
      flags_r  <= in_tcp_flags;
      secs_r   <= in_time_seconds;
      usec_r   <= in_time_micros;
      rslot_r  <= in_read_slot;
    end
  end

  // entry store, read address issued at the accept edge
  fpsr_entry_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (AW'(count_eff)),
    .wr_data (wr_entry),
    .rd_en   (accept),
    .rd_addr (AW'(in_read_slot)),
    .rd_data (rd_entry)
  );

  assign cur_snap = '{seq: seq_r, ack: ack_r, len: plen_r, flags: flags_r};

  fpsr_dir_state u_dir (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (dir_upd),
    .cur     (cur_snap),
    .dir_sel (!client_r),
    .match   (dir_match)
  );

  // execute-cycle decode
  assign is_read   = (cmd_r == fpsr_pkg::CMD_READ) || (cmd_r == fpsr_pkg::CMD_READ_ALT);
  assign new_flow  = (cmd_r == fpsr_pkg::CMD_NEW);
  assign count_eff = new_flow ? '0 : count_r;
  assign has_room  = count_eff < CNT_W'(MAX_ENTRIES);
  assign read_hit  = (CMP_W'(rslot_r) < CMP_W'(count_r)) &&
                     (CMP_W'(rslot_r) < CMP_W'(MAX_ENTRIES));
  assign dup       = skip_dup_r && (proto_r == fpsr_pkg::PROTO_TCP) && dir_match &&
                     (count_eff != '0);
  assign zero_drop = (plen_r == 16'd0) && !inc_zero_r;

  assign wr_entry = '{size: olen_r, flags: flags_r, seconds: secs_r, micros: usec_r,
                      client: client_r};

  // result and state update for the beat in execute
  always_comb begin
    count_nxt     = count_r;
    mem_wr        = 1'b0;
    dir_upd       = '0;
    dir_upd.dir   = !client_r;
    status_nxt    = fpsr_pkg::ST_RECORDED;
    slot_nxt      = '0;
    ecount_nxt    = '0;
    esize_nxt     = '0;
    eflags_nxt    = '0;
    esecs_nxt     = '0;
    eusec_nxt     = '0;
    edir_nxt      = 2'sb00;
    if (busy_r) begin
      if (is_read) begin
        slot_nxt   = rslot_r;
        ecount_nxt = 6'(count_r);
        if (read_hit) begin
          status_nxt = fpsr_pkg::ST_READ_OK;
          esize_nxt  = rd_entry.size;
          eflags_nxt = rd_entry.flags;
          esecs_nxt  = rd_entry.seconds;
          eusec_nxt  = rd_entry.micros;
          edir_nxt   = rd_entry.client ? 2'sb01 : 2'sb11;
        end else begin
          status_nxt = fpsr_pkg::ST_READ_EMPTY;
        end
      end else begin
        dir_upd.clear = new_flow;
        count_nxt     = count_eff;
        if (dup) begin
          status_nxt = fpsr_pkg::ST_DUP_DROP;
        end else begin
          dir_upd.write = 1'b1;
          if (zero_drop) begin
            status_nxt = fpsr_pkg::ST_ZERO_DROP;
          end else if (has_room) begin
            mem_wr     = 1'b1;
            count_nxt  = count_eff + CNT_W'(1);
            status_nxt = fpsr_pkg::ST_RECORDED;
            slot_nxt   = 5'(count_eff);
            esize_nxt  = olen_r;
            eflags_nxt = flags_r;
            esecs_nxt  = secs_r;
            eusec_nxt  = usec_r;
            edir_nxt   = client_r ? 2'sb01 : 2'sb11;
          end else begin
            status_nxt = fpsr_pkg::ST_LIST_FULL;
          end
        end
        ecount_nxt = 6'(count_nxt);
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (busy_r) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      ecount_r <= ecount_nxt;
      esize_r  <= esize_nxt;
      eflags_r <= eflags_nxt;
      esecs_r  <= esecs_nxt;
      eusec_r  <= eusec_nxt;
      edir_r   <= edir_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_slot            = slot_r;
  assign out_entry_count     = ecount_r;
  assign out_entry_size      = esize_r;
  assign out_entry_flags     = eflags_r;
  assign out_entry_seconds   = esecs_r;
  assign out_entry_micros    = eusec_r;
  assign out_entry_direction = edir_r;

endmodule

// ===== hdl/fpsr_entry_mem.sv =====
// entry store of the recorder: one write port, one registered read port
// depends on fpsr_pkg for the entry record type
module fpsr_entry_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  fpsr_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output fpsr_pkg::entry_t rd_data
);

  fpsr_pkg::entry_t mem [DEPTH];
  fpsr_pkg::entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/fpsr_dir_state.sv =====
// per-direction tcp snapshot and retransmission match
// depends on fpsr_pkg for snapshot, update struct and wrap limit
module fpsr_dir_state (
  input  logic                clk,
  input  logic                rst_n,
  input  fpsr_pkg::dir_upd_t  upd,
  input  fpsr_pkg::tcp_snap_t cur,
  input  logic                dir_sel,
  output logic                match
);

  fpsr_pkg::tcp_snap_t last_r [2];
  fpsr_pkg::tcp_snap_t last_sel;

  // cur is not ahead of last when behind it by no more than the wrap limit
  function automatic logic not_ahead(logic [31:0] c, logic [31:0] l);
    logic [31:0] diff;
    diff = l - c;
    return (c <= l) && (diff <= fpsr_pkg::WRAP_LIMIT);
  endfunction

  // clear on a new flow, then store the packet of the chosen direction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r[0] <= '0;
      last_r[1] <= '0;
    end else begin
      for (int i = 0; i < 2; i++) begin
        if (upd.write && (upd.dir == 1'(i))) begin
          last_r[i] <= cur;
        end else if (upd.clear) begin
          last_r[i] <= '0;
        end
      end
    end
  end

  // compare against the snapshot of the packet's direction
  always_comb begin
    last_sel = last_r[dir_sel];
    match = not_ahead(cur.seq, last_sel.seq) && not_ahead(cur.ack, last_sel.ack) &&
            (cur.len == last_sel.len) && (cur.flags == last_sel.flags);
  end

endmodule

// ===== hdl/fpsr_checker.sv =====
// port-level checker for the recorder, bound to the top level
// depends on fpsr_pkg and flow_packet_stats_recorder_core_macros.svh
`include "flow_packet_stats_recorder_core_macros.svh"

module fpsr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [2:0]        out_status,
  input logic [4:0]        out_slot,
  input logic [5:0]        out_entry_count,
  input logic signed [1:0] out_entry_direction
);

  // an accepted beat occupies exactly one execute cycle
  `FPSR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `FPSR_ASSERT_NEXT(a_busy_one, clk, rst_n, busy, !busy && out_valid)

  // a recorded entry is the last one counted
  `FPSR_ASSERT_NOW(a_rec_slot, clk, rst_n, out_valid && (out_status == fpsr_pkg::ST_RECORDED), (out_entry_count != 6'd0) && (out_slot == 5'(out_entry_count - 6'd1)))

  // a successful read lies below the count
  `FPSR_ASSERT_NOW(a_read_in_range, clk, rst_n, out_valid && (out_status == fpsr_pkg::ST_READ_OK), {1'b0, out_slot} < out_entry_count)

  // an empty read carries no direction
  `FPSR_ASSERT_NOW(a_empty_dir, clk, rst_n, out_valid && (out_status == fpsr_pkg::ST_READ_EMPTY), out_entry_direction == 2'sb00)

endmodule

bind flow_packet_stats_recorder_core fpsr_checker u_fpsr_checker (.*);
